FILE: rtl/sjrf_pkg.sv
`default_nettype none

package sjrf_pkg;

    // Widths of the request and result fields.
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 13;
    localparam int MODE_W  = 2;

    // Run length saturates here when no block end arrives.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Charset mode codes. The unused code behaves as MODE_ALL.
    localparam logic [MODE_W-1:0] MODE_JAPANESE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ASCII    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALL      = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MIN_RUN_LENGTH = 1'b0;
    localparam logic CFG_CHARSET_MODE   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] MIN_RUN_LENGTH_RESET = 13'd4;
    localparam logic [MODE_W-1:0]  CHARSET_MODE_RESET   = MODE_ALL;

    // Classification of one byte, shared by the run logic.
    typedef struct packed {
        logic is_lead;
        logic is_trail;
        logic is_kana;
        logic is_ascii;
        logic is_letter;
        logic is_high;
    } t_byte_class;

    // One reported run.
    typedef struct packed {
        logic [ADDR_W-1:0]  string_address;
        logic [COUNT_W-1:0] string_length;
        logic               saw_japanese;
        logic               saw_letters;
        logic               last_result;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/sjrf_byte_class.sv
`default_nettype none

// Sorts one byte into the Shift-JIS and ASCII classes used by the run logic.
module sjrf_byte_class
    import sjrf_pkg::*;
(
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_byte_class            o_class
);

    always_comb begin
        o_class.is_lead   = i_byte inside {[8'h81:8'h9F], [8'hE0:8'hFC]};
        o_class.is_trail  = i_byte inside {[8'h40:8'h7E], [8'h80:8'hFC]};
        o_class.is_kana   = i_byte inside {[8'hA1:8'hDF]};
        o_class.is_ascii  = i_byte inside {[8'h20:8'h7E]};
        o_class.is_letter = i_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        o_class.is_high   = i_byte[BYTE_W-1];
    end

endmodule

`default_nettype wire

FILE: rtl/sjrf_result_fifo.sv
`default_nettype none

// Small result queue. Takes zero, one or two results a cycle and gives one when popped.
// The depth must be a power of two and at least two.
module sjrf_result_fifo
    import sjrf_pkg::*;
#(
    parameter int P_DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic [1:0] i_push_count,
    input  wire t_result i_data0,
    input  wire t_result i_data1,
    input  wire logic    i_pop,
    output t_result      o_data,
    output logic         o_valid,
    output logic         o_room2
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_result         r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= CW'(P_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_push_count);
        n_rd_ptr = r_rd_ptr + AW'(i_pop);
        n_count  = CW'(r_count + CW'(i_push_count) - CW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_data1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/shift_jis_string_run_finder.sv
`default_nettype none

// Shift-JIS string run finder. Each request carries one memory byte, its scan
// address and a flag that marks the last byte of a read block. The block grows
// a run of text under the charset mode (Japanese Shift-JIS, ASCII only, or all
// printable bytes) and reports the run as a result when it ends, if it meets
// the minimum length and the mode's validity rule. A request is taken every
// cycle unless the input stalls; a taken byte waits in the input register
// until the result queue has room for two results, then is classified and
// applied to the run. One byte can cause two results (a lead byte that fails
// to pair ends one run, and the next byte forms a one-byte run at a block
// end); results drain through a queue of P_QUEUE_DEPTH entries at one per
// cycle while the output is not stalled, and the input stalls only while
// that queue has no room for two more results. Configuration writes are
// applied at once and must only be made while the block is idle.
module shift_jis_string_run_finder
    import sjrf_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port.
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [COUNT_W-1:0] i_cfg_data,
    // Byte request channel.
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [BYTE_W-1:0]  i_data_byte,
    input  wire logic [ADDR_W-1:0]  i_byte_address,
    input  wire logic               i_block_end,
    // Result channel.
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [ADDR_W-1:0]       o_string_address,
    output logic [COUNT_W-1:0]      o_string_length,
    output logic                    o_saw_japanese,
    output logic                    o_saw_letters,
    output logic                    o_last_result
);

    // Configuration registers.
    logic [COUNT_W-1:0] r_min_len;
    logic [MODE_W-1:0]  r_mode;

    // Input register.
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_bend;

    // Run state.
    logic               r_active;
    logic [ADDR_W-1:0]  r_start;
    logic [COUNT_W-1:0] r_count;
    logic               r_jseen;
    logic               r_lseen;
    logic               r_lead_pending;

    logic               n_active;
    logic [ADDR_W-1:0]  n_start;
    logic [COUNT_W-1:0] n_count;
    logic               n_jseen;
    logic               n_lseen;
    logic               n_lead_pending;

    t_byte_class        w_class;
    logic               w_mode_jp;
    logic               w_mode_ascii;
    logic               w_take;
    logic               w_proc;
    logic               w_room2;

    // Pending lead byte resolution.
    logic               w_pair;
    logic               w_fail_lead;
    logic               w_fire_a;

    // Run state once a failed lead byte has closed the old run.
    logic               w_active1;
    logic [COUNT_W-1:0] w_count1;
    logic               w_jseen1;
    logic               w_lseen1;

    // Handling of the current byte.
    logic               w_accept;
    logic               w_hold;
    logic               w_reject;
    logic               w_add_j;
    logic               w_add_l;
    logic               w_grow;
    logic [COUNT_W:0]   w_sum;

    // Run state after the current byte has joined.
    logic               w_active2;
    logic [ADDR_W-1:0]  w_start2;
    logic [COUNT_W-1:0] w_count2;
    logic               w_jseen2;
    logic               w_lseen2;
    logic               w_end2;
    logic               w_fire_b;

    t_result            w_res_a;
    t_result            w_res_b;
    t_result            w_push0;
    logic [1:0]         w_push_count;
    t_result            w_head;
    logic               w_pop;

    // A run is reported if it holds bytes, meets the minimum and passes the
    // validity rule of the mode: Japanese text for Japanese mode, a letter
    // for ASCII mode, and either one for all-printable mode.
    function automatic logic run_reportable(
        input logic               active,
        input logic [COUNT_W-1:0] count,
        input logic               jseen,
        input logic               lseen,
        input logic [COUNT_W-1:0] min_len,
        input logic [MODE_W-1:0]  mode
    );
        logic ok;
        case (mode)
            MODE_JAPANESE: ok = jseen;
            MODE_ASCII:    ok = lseen;
            default:       ok = jseen | lseen;
        endcase
        return active && (count != '0) && (count >= min_len) && ok;
    endfunction

    sjrf_byte_class u_byte_class (
        .i_byte  (r_byte),
        .o_class (w_class)
    );

    // The input register empties whenever its byte is applied, so a new
    // request can be taken in the same cycle.
    assign o_stall = r_in_valid && !w_room2;
    assign w_take  = i_valid && !o_stall;
    assign w_proc  = r_in_valid && w_room2;

    assign w_mode_jp    = (r_mode == MODE_JAPANESE);
    assign w_mode_ascii = (r_mode == MODE_ASCII);

    always_comb begin
        // A held lead byte pairs only with a trail byte while the mode is
        // still Japanese; otherwise the run ends without it.
        w_pair      = r_lead_pending && w_mode_jp && w_class.is_trail;
        w_fail_lead = r_lead_pending && !w_pair;
        w_fire_a    = w_fail_lead &&
                      run_reportable(r_active, r_count, r_jseen, r_lseen, r_min_len, r_mode);

        w_active1 = w_fail_lead ? 1'b0 : r_active;
        w_count1  = w_fail_lead ? '0   : r_count;
        w_jseen1  = w_fail_lead ? 1'b0 : r_jseen;
        w_lseen1  = w_fail_lead ? 1'b0 : r_lseen;

        // Classify the byte under the current mode. A paired trail byte is
        // consumed by the pair and not looked at again.
        w_accept = 1'b0;
        w_hold   = 1'b0;
        w_reject = 1'b0;
        w_add_j  = 1'b0;
        w_add_l  = 1'b0;
        if (!w_pair) begin
            if (w_mode_jp) begin
                if (w_class.is_lead) begin
                    // A lead byte at a block end cannot pair; the block end
                    // closes the run and the byte is dropped.
                    w_hold = !r_bend;
                end else if (w_class.is_kana) begin
                    w_accept = 1'b1;
                    w_add_j  = 1'b1;
                end else if (w_class.is_ascii) begin
                    w_accept = 1'b1;
                    w_add_l  = w_class.is_letter;
                end else begin
                    w_reject = 1'b1;
                end
            end else if (w_mode_ascii) begin
                w_accept = w_class.is_ascii;
                w_reject = !w_class.is_ascii;
                w_add_l  = w_class.is_letter;
            end else begin
                w_accept = w_class.is_ascii || w_class.is_high;
                w_reject = !w_accept;
                w_add_l  = w_class.is_letter;
                w_add_j  = w_class.is_lead || w_class.is_kana;
            end
        end

        // Grow the run by one byte, or by two for a lead/trail pair, with the
        // count saturating at its maximum.
        w_grow = w_pair || w_accept;
        w_sum  = {1'b0, w_count1} + (w_pair ? (COUNT_W+1)'(2) : (COUNT_W+1)'(1));

        w_active2 = w_active1 || w_grow;
        if (w_grow && !w_active1) begin
            // A pair starts at the held lead byte, whose address is already
            // in the start register.
            w_start2 = w_pair ? r_start : r_addr;
        end else begin
            w_start2 = r_start;
        end
        if (w_grow) begin
            w_count2 = w_sum[COUNT_W] ? COUNT_MAX : w_sum[COUNT_W-1:0];
        end else begin
            w_count2 = w_count1;
        end
        w_jseen2 = w_jseen1 || w_pair || (w_accept && w_add_j);
        w_lseen2 = w_lseen1 || (w_accept && w_add_l);

        // The run closes at a rejected byte or at a block end.
        w_end2   = r_bend || w_reject;
        w_fire_b = w_end2 &&
                   run_reportable(w_active2, w_count2, w_jseen2, w_lseen2, r_min_len, r_mode);
    end

    // Results in order: the run closed by a failed lead byte first, then the
    // run closed by this byte. The later one carries the last-result flag.
    always_comb begin
        w_res_a.string_address = r_start;
        w_res_a.string_length  = r_count;
        w_res_a.saw_japanese   = r_jseen;
        w_res_a.saw_letters    = r_lseen;
        w_res_a.last_result    = !w_fire_b;

        w_res_b.string_address = w_start2;
        w_res_b.string_length  = w_count2;
        w_res_b.saw_japanese   = w_jseen2;
        w_res_b.saw_letters    = w_lseen2;
        w_res_b.last_result    = 1'b1;

        w_push0 = w_fire_a ? w_res_a : w_res_b;
        if (w_proc) begin
            w_push_count = 2'(w_fire_a) + 2'(w_fire_b);
        end else begin
            w_push_count = 2'd0;
        end
    end

    // Next run state.
    always_comb begin
        n_active       = r_active;
        n_start        = r_start;
        n_count        = r_count;
        n_jseen        = r_jseen;
        n_lseen        = r_lseen;
        n_lead_pending = r_lead_pending;
        if (w_proc) begin
            n_lead_pending = w_hold;
            if (w_end2) begin
                n_active = 1'b0;
                n_start  = w_start2;
                n_count  = '0;
                n_jseen  = 1'b0;
                n_lseen  = 1'b0;
            end else begin
                n_active = w_active2;
                n_count  = w_count2;
                n_jseen  = w_jseen2;
                n_lseen  = w_lseen2;
                // A held lead byte with no open run records its own address as the run start.
                n_start  = (w_hold && !w_active1) ? r_addr : w_start2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len      <= MIN_RUN_LENGTH_RESET;
            r_mode         <= CHARSET_MODE_RESET;
            r_in_valid     <= 1'b0;
            r_active       <= 1'b0;
            r_start        <= '0;
            r_count        <= '0;
            r_jseen        <= 1'b0;
            r_lseen        <= 1'b0;
            r_lead_pending <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_RUN_LENGTH: r_min_len <= i_cfg_data;
                    CFG_CHARSET_MODE:   r_mode    <= i_cfg_data[MODE_W-1:0];
                    default:            r_mode    <= r_mode;
                endcase
            end
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            r_active       <= n_active;
            r_start        <= n_start;
            r_count        <= n_count;
            r_jseen        <= n_jseen;
            r_lseen        <= n_lseen;
            r_lead_pending <= n_lead_pending;
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_data_byte;
            r_addr <= i_byte_address;
            r_bend <= i_block_end;
        end
    end

    assign w_pop = o_valid && !i_stall;

    sjrf_result_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_result_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_push_count),
        .i_data0      (w_push0),
        .i_data1      (w_res_b),
        .i_pop        (w_pop),
        .o_data       (w_head),
        .o_valid      (o_valid),
        .o_room2      (w_room2)
    );

    assign o_string_address = w_head.string_address;
    assign o_string_length  = w_head.string_length;
    assign o_saw_japanese   = w_head.saw_japanese;
    assign o_saw_letters    = w_head.saw_letters;
    assign o_last_result    = w_head.last_result;

endmodule

`default_nettype wire
